[rtl/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the hex record parser
// Character classes, queue entry, report codes and record type codes.
// ----------------------------------------------------------------------------
package ihex_pkg;

   // Depth of the queue between front and back
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw    = $clog2(QueueDepth);

   // Record types
   localparam logic [7:0] REC_DATA  = 8'h00;
   localparam logic [7:0] REC_EOF   = 8'h01;
   localparam logic [7:0] REC_SEG   = 8'h02;
   localparam logic [7:0] REC_LIN   = 8'h04;
   localparam logic [7:0] REC_START = 8'h05;

   // Record layout
   localparam logic [8:0] HDR_LEN = 9'd5;
   localparam logic [8:0] POS_MAX = 9'd511;
   localparam logic [8:0] POS_CNT = 9'd0;
   localparam logic [8:0] POS_OFH = 9'd1;
   localparam logic [8:0] POS_OFL = 9'd2;
   localparam logic [8:0] POS_TYP = 9'd3;
   localparam logic [8:0] POS_DAT = 9'd4;

   // Result kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Report codes
   typedef enum logic [3:0] {
      ST_DATA      = 4'd0,
      ST_EOF       = 4'd1,
      ST_EXT_SEG   = 4'd2,
      ST_EXT_LIN   = 4'd3,
      ST_START_LIN = 4'd4,
      ST_NO_COLON  = 4'd5,
      ST_ODD_LEN   = 4'd6,
      ST_NON_HEX   = 4'd7,
      ST_CHECKSUM  = 4'd8,
      ST_SIZE      = 4'd9,
      ST_BAD_LEN   = 4'd10,
      ST_BAD_TYPE  = 4'd11
   } status_type;

   // One classified character as it travels from front to back
   typedef struct packed {
      logic       is_space;
      logic       is_colon;
      logic       hex_ok;
      logic [3:0] hex_val;
   } char_class_type;

   // Queue status seen by the front, the back and the top level
   typedef struct packed {
      logic full;
      logic valid;
   } queue_stat_type;

endpackage

[rtl/ihex_if.sv]
// ----------------------------------------------------------------------------
// ihex_req_if / ihex_rsp_if: character and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] address;
   logic [7:0]  data_byte;
   logic [3:0]  status;
   logic [15:0] line_number;

   modport source (output valid, output kind, output address, output data_byte,
                   output status, output line_number, input ready);
   modport sink   (input valid, input kind, input address, input data_byte,
                   input status, input line_number, output ready);
endinterface

[rtl/intel_hex_record_parser.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_parser: hex record text parser
// Character front end, short queue, record decoder with output register.
//
//   channel   dir   beat                  ports
//   req_chan  in    one text character    valid, ready, char_code
//   rsp_chan  out   byte or line report   valid, ready, kind, address,
//                                         data_byte, status, line_number
//
// One character a cycle while the queue has room; a character is stored in a
// queue slot, and its result in the output register. Throughput is set by the
// decoder, which retires one queue entry a cycle while the output register is
// free or taken. Reset clears the queue, phase, address base and line count.
// A stalled result holds there; the 4-entry queue takes characters until full.
// ----------------------------------------------------------------------------
module intel_hex_record_parser (
   input  logic       clock,
   input  logic       reset,
   ihex_req_if.sink   req_chan,
   ihex_rsp_if.source rsp_chan
);

   ihex_pkg::queue_stat_type q_stat;
   ihex_pkg::char_class_type push_entry;
   ihex_pkg::char_class_type pop_entry;
   logic                     push;
   logic                     pop;

   ihex_front u_front (
      .req_chan   (req_chan),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   ihex_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_stat     (q_stat)
   );

   ihex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   // A full queue must refuse characters
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_chan.ready)
      else $error("queue full but input ready");

   // The decoder pops only what the queue holds
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.valid)
      else $error("pop from empty queue");

   // After an error or eof report is taken, nothing more comes out
   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.kind == ihex_pkg::KIND_REPORT &&
       rsp_chan.status != ihex_pkg::ST_DATA && rsp_chan.status != ihex_pkg::ST_EXT_SEG &&
       rsp_chan.status != ihex_pkg::ST_EXT_LIN && rsp_chan.status != ihex_pkg::ST_START_LIN)
      |=> !rsp_chan.valid)
      else $error("result after stop");

   // Every result belongs to some counted line
   a_line_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.line_number != 16'd0)
      else $error("result with zero line number");

endmodule

[rtl/ihex_front.sv]
// ----------------------------------------------------------------------------
// ihex_front: character intake
// Accepts one character a beat and classifies it for the back end.
// ----------------------------------------------------------------------------
module ihex_front (
   ihex_req_if.sink                   req_chan,
   input  ihex_pkg::queue_stat_type   q_stat,
   output logic                       push,
   output ihex_pkg::char_class_type   push_entry
);

   logic [7:0] c;

   assign c = req_chan.char_code;

   // Take a beat whenever the queue has room
   assign req_chan.ready = ~q_stat.full;
   assign push           = req_chan.valid & ~q_stat.full;

   // Classify: whitespace, colon, uppercase hex digit
   always_comb begin
      push_entry          = '0;
      push_entry.is_space = (c == 8'd32) || (c == 8'd9) || (c == 8'd10) ||
                            (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
      push_entry.is_colon = (c == 8'h3A);
      if (c >= 8'h30 && c <= 8'h39) begin
         push_entry.hex_ok  = 1'b1;
         push_entry.hex_val = c[3:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
         push_entry.hex_ok  = 1'b1;
         push_entry.hex_val = c[3:0] + 4'd9;
      end
   end

endmodule

[rtl/ihex_queue.sv]
// ----------------------------------------------------------------------------
// ihex_queue: short queue between front and back
// Holds classified characters so either side may stall on its own.
// ----------------------------------------------------------------------------
module ihex_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ihex_pkg::char_class_type   push_entry,
   input  logic                       pop,
   output ihex_pkg::char_class_type   pop_entry,
   output ihex_pkg::queue_stat_type   q_stat
);

   ihex_pkg::char_class_type          slot_ff [ihex_pkg::QueueDepth];
   logic [ihex_pkg::QueueAw-1:0]      wr_ff, wr_in;
   logic [ihex_pkg::QueueAw-1:0]      rd_ff, rd_in;
   logic [ihex_pkg::QueueAw:0]        cnt_ff, cnt_in;

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   assign pop_entry    = slot_ff[rd_ff];
   assign q_stat.full  = (cnt_ff == (ihex_pkg::QueueAw+1)'(ihex_pkg::QueueDepth));
   assign q_stat.valid = (cnt_ff != '0);

endmodule

[rtl/ihex_back.sv]
// ----------------------------------------------------------------------------
// ihex_back: record decoder
// Walks each line, decodes bytes, emits pending bytes and line reports.
// ----------------------------------------------------------------------------
module ihex_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ihex_pkg::queue_stat_type   q_stat,
   input  ihex_pkg::char_class_type   pop_entry,
   output logic                       pop,
   ihex_rsp_if.source                 rsp_chan
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_LINE = 3'b010,
      PH_STOP = 3'b100
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic                  nib_ff, nib_in;
   logic [3:0]            high_ff, high_in;
   logic [8:0]            pos_ff, pos_in;
   logic [7:0]            sum_ff, sum_in;
   logic [7:0]            count_ff, count_in;
   logic [7:0]            offhi_ff, offhi_in;
   logic [7:0]            rkind_ff, rkind_in;
   logic [31:0]           coll_ff, coll_in;
   logic [31:0]           base_ff, base_in;
   logic [31:0]           addr_ff, addr_in;
   logic [15:0]           lcnt_ff, lcnt_in;
   logic                  nocolon_ff, nocolon_in;
   logic                  nonhex_ff, nonhex_in;

   logic                  ovalid_ff, ovalid_in;
   logic                  okind_ff, okind_in;
   logic [31:0]           oaddr_ff, oaddr_in;
   logic [7:0]            obyte_ff, obyte_in;
   ihex_pkg::status_type  ostat_ff, ostat_in;
   logic [15:0]           oline_ff, oline_in;

   logic                  emit;
   logic [7:0]            b;
   logic [8:0]            dat_idx;
   logic                  size_bad;
   logic [15:0]           v16;
   ihex_pkg::status_type  rep;
   logic [31:0]           rep_addr;

   ihex_pkg::char_class_type e;

   assign e   = pop_entry;
   assign pop = q_stat.valid & (~ovalid_ff | rsp_chan.ready);
   assign b   = {high_ff, e.hex_val};
   assign dat_idx  = pos_ff - ihex_pkg::POS_DAT;
   assign size_bad = (pos_ff < ihex_pkg::HDR_LEN) ||
                     (pos_ff != ({1'b0, count_ff} + ihex_pkg::HDR_LEN));
   assign v16 = coll_ff[15:0];

   // Decide the line-end report
   always_comb begin
      rep      = ihex_pkg::ST_DATA;
      rep_addr = '0;
      if (nocolon_ff) begin
         rep = ihex_pkg::ST_NO_COLON;
      end else if (nib_ff) begin
         rep = ihex_pkg::ST_ODD_LEN;
      end else if (nonhex_ff) begin
         rep = ihex_pkg::ST_NON_HEX;
      end else if (sum_ff != 8'd0) begin
         rep = ihex_pkg::ST_CHECKSUM;
      end else if (size_bad) begin
         rep = ihex_pkg::ST_SIZE;
      end else begin
         case (rkind_ff)
            ihex_pkg::REC_DATA: rep = ihex_pkg::ST_DATA;
            ihex_pkg::REC_EOF:  rep = ihex_pkg::ST_EOF;
            ihex_pkg::REC_SEG: begin
               rep = (count_ff == 8'd2) ? ihex_pkg::ST_EXT_SEG : ihex_pkg::ST_BAD_LEN;
            end
            ihex_pkg::REC_LIN: begin
               rep = (count_ff == 8'd2) ? ihex_pkg::ST_EXT_LIN : ihex_pkg::ST_BAD_LEN;
            end
            ihex_pkg::REC_START: begin
               if (count_ff == 8'd4) begin
                  rep      = ihex_pkg::ST_START_LIN;
                  rep_addr = coll_ff;
               end else begin
                  rep = ihex_pkg::ST_BAD_LEN;
               end
            end
            default: rep = ihex_pkg::ST_BAD_TYPE;
         endcase
      end
   end

   // Step the line state for one popped character
   always_comb begin
      phase_in   = phase_ff;
      nib_in     = nib_ff;
      high_in    = high_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      offhi_in   = offhi_ff;
      rkind_in   = rkind_ff;
      coll_in    = coll_ff;
      base_in    = base_ff;
      addr_in    = addr_ff;
      lcnt_in    = lcnt_ff;
      nocolon_in = nocolon_ff;
      nonhex_in  = nonhex_ff;
      emit       = 1'b0;
      okind_in   = ihex_pkg::KIND_BYTE;
      oaddr_in   = '0;
      obyte_in   = '0;
      ostat_in   = ihex_pkg::ST_DATA;
      if (pop) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!e.is_space) begin
                  phase_in   = PH_LINE;
                  lcnt_in    = (lcnt_ff == 16'hFFFF) ? lcnt_ff : lcnt_ff + 16'd1;
                  nib_in     = 1'b0;
                  high_in    = '0;
                  pos_in     = '0;
                  sum_in     = '0;
                  count_in   = '0;
                  offhi_in   = '0;
                  rkind_in   = '0;
                  coll_in    = '0;
                  nocolon_in = ~e.is_colon;
                  nonhex_in  = 1'b0;
               end
            end
            PH_LINE: begin
               if (e.is_space) begin
                  // Line end: report, move the base, stop on error or eof
                  emit     = 1'b1;
                  okind_in = ihex_pkg::KIND_REPORT;
                  oaddr_in = rep_addr;
                  ostat_in = rep;
                  if (rep == ihex_pkg::ST_EXT_SEG) begin
                     base_in = {12'd0, v16, 4'd0};
                  end else if (rep == ihex_pkg::ST_EXT_LIN) begin
                     base_in = {v16, 16'd0};
                  end
                  if (rep == ihex_pkg::ST_DATA || rep == ihex_pkg::ST_EXT_SEG ||
                      rep == ihex_pkg::ST_EXT_LIN || rep == ihex_pkg::ST_START_LIN) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_STOP;
                  end
               end else if (!nocolon_ff) begin
                  nib_in    = ~nib_ff;
                  nonhex_in = nonhex_ff | ~e.hex_ok;
                  if (!nonhex_in) begin
                     if (!nib_ff) begin
                        high_in = e.hex_val;
                     end else begin
                        // Full byte: sum it and file it by position
                        sum_in = sum_ff + b;
                        case (pos_ff)
                           ihex_pkg::POS_CNT: count_in = b;
                           ihex_pkg::POS_OFH: offhi_in = b;
                           ihex_pkg::POS_OFL: addr_in  = base_ff + {16'd0, offhi_ff, b};
                           ihex_pkg::POS_TYP: rkind_in = b;
                           default: begin
                              if (dat_idx < {1'b0, count_ff}) begin
                                 coll_in = {coll_ff[23:0], b};
                                 if (rkind_ff == ihex_pkg::REC_DATA) begin
                                    emit     = 1'b1;
                                    oaddr_in = addr_ff;
                                    obyte_in = b;
                                    addr_in  = addr_ff + 32'd1;
                                 end
                              end
                           end
                        endcase
                        pos_in = (pos_ff == ihex_pkg::POS_MAX) ? pos_ff : pos_ff + 9'd1;
                     end
                  end
               end
            end
            PH_STOP: begin
               phase_in = PH_STOP;
            end
            default: begin
               phase_in = PH_STOP;
            end
         endcase
      end
      oline_in  = lcnt_ff;
      ovalid_in = emit | (ovalid_ff & ~rsp_chan.ready);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         base_ff   <= '0;
         lcnt_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         base_ff   <= base_in;
         lcnt_ff   <= lcnt_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Line working registers, cleared at each line start but for the address
   always_ff @(posedge clock) begin
      nib_ff     <= nib_in;
      high_ff    <= high_in;
      pos_ff     <= pos_in;
      sum_ff     <= sum_in;
      count_ff   <= count_in;
      offhi_ff   <= offhi_in;
      rkind_ff   <= rkind_in;
      coll_ff    <= coll_in;
      addr_ff    <= addr_in;
      nocolon_ff <= nocolon_in;
      nonhex_ff  <= nonhex_in;
   end

   // Output register: load on emit, hold while stalled
   always_ff @(posedge clock) begin
      if (emit) begin
         okind_ff <= okind_in;
         oaddr_ff <= oaddr_in;
         obyte_ff <= obyte_in;
         ostat_ff <= ostat_in;
         oline_ff <= oline_in;
      end
   end

   assign rsp_chan.valid       = ovalid_ff;
   assign rsp_chan.kind        = okind_ff;
   assign rsp_chan.address     = oaddr_ff;
   assign rsp_chan.data_byte   = obyte_ff;
   assign rsp_chan.status      = ostat_ff;
   assign rsp_chan.line_number = oline_ff;

endmodule
